// File: hdl/unix_seconds_to_calendar_date_macros.svh
// Assertion macros shared by the calendar date converter.
`ifndef UNIX_SECONDS_TO_CALENDAR_DATE_MACROS_SVH
`define UNIX_SECONDS_TO_CALENDAR_DATE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define USCD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("calendar date converter check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define USCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("calendar date converter check failed");

`endif

// File: hdl/uscd_pkg.sv
// Shared types, constants and the month length function of the date converter.
package uscd_pkg;

   // Field widths of the items.
   localparam int SECONDS_W = 32;
   localparam int YEAR_W    = 12;
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 5;
   localparam int HOUR_W    = 5;
   localparam int MINUTE_W  = 6;
   localparam int SECOND_W  = 6;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   // Time constants in seconds.
   localparam logic [31:0] SECS_PER_MINUTE = 32'd60;
   localparam logic [31:0] SECS_PER_HOUR   = 32'd3600;
   localparam logic [31:0] SECS_PER_DAY    = 32'd86400;
   localparam logic [31:0] SECS_LEAP_YEAR  = 32'd31622400;
   localparam logic [31:0] SECS_PLAIN_YEAR = 32'd31536000;
   localparam logic [31:0] SECS_DAYS28     = 32'd2419200;
   localparam logic [31:0] SECS_DAYS29     = 32'd2505600;
   localparam logic [31:0] SECS_DAYS30     = 32'd2592000;
   localparam logic [31:0] SECS_DAYS31     = 32'd2678400;

   // Epoch year and its residues for the century and 400-year rules.
   localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
   localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
   localparam logic [8:0]  EPOCH_MOD400 = 9'd370;
   localparam logic [6:0]  MOD100_LAST  = 7'd99;
   localparam logic [8:0]  MOD400_LAST  = 9'd399;

   // Month codes.
   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_MAR = 4'd3;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_MAY = 4'd5;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_JUL = 4'd7;
   localparam logic [3:0] MONTH_AUG = 4'd8;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_OCT = 4'd10;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   // Reciprocal of 60 scaled by 2^18 and rounded up; exact for every value below 3600.
   localparam logic [12:0] MIN_RECIP       = 13'd4370;
   localparam int          MIN_RECIP_SHIFT = 18;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_YEAR,
      ST_MONTH,
      ST_DAY,
      ST_HOUR,
      ST_MINUTE,
      ST_OUTPUT
   } state_type;

   // Datapath operations.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_YEAR,
      OP_MONTH,
      OP_DAY,
      OP_HOUR,
      OP_MINUTE,
      OP_OUTPUT
   } op_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      op_type op;
   } cmd_type;

   // Status from the datapath: whether the remainder covers another unit.
   typedef struct packed {
      logic year_ge;
      logic month_ge;
      logic day_ge;
      logic hour_ge;
   } status_type;

   // Length of a month in seconds.
   function automatic logic [31:0] month_secs(input logic [3:0] month, input logic leap);
      logic [31:0] secs;
      case (month) inside
         MONTH_FEB: secs = leap ? SECS_DAYS29 : SECS_DAYS28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: secs = SECS_DAYS30;
         default: secs = SECS_DAYS31;
      endcase
      return secs;
   endfunction

endpackage

// File: hdl/unix_seconds_to_calendar_date.sv
// Converts one item at a time: after loading, whole years, months, days and hours are
// taken off the remainder in turn, then the minute is found and the result is registered.
// The next item is accepted only after the result is registered, and a result still held
// by the receiver keeps the next one from being registered until it is taken.
// The cost is set by a single shared subtractor stepping one unit a cycle.
// Reset (synchronous, active high) clears the controller and the output valid flag.
module unix_seconds_to_calendar_date (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] unix_seconds
   input  logic [uscd_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [11:0] year, [15:12] month, [20:16] day, [25:21] hour, [31:26] minute,
   // [37:32] second, [39:38] zero
   output logic [uscd_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

`include "unix_seconds_to_calendar_date_macros.svh"

   uscd_pkg::cmd_type    cmd;
   uscd_pkg::status_type status;
   logic                 out_write;
   logic                 rsp_month_ok;

   // Sequencing of the conversion steps.
   uscd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Arithmetic and storage.
   uscd_datapath u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_tdata),
      .status   (status),
      .rsp_data (rsp_tdata)
   );

   // Terms used by the checks below.
   assign out_write    = cmd.op == uscd_pkg::OP_OUTPUT;
   assign rsp_month_ok = (rsp_tdata[15:12] >= uscd_pkg::MONTH_JAN)
                         && (rsp_tdata[15:12] <= uscd_pkg::MONTH_DEC);

   // An accepted item keeps the input closed for at least the next cycle.
   `USCD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

   // A new result is only written into a free or draining output register.
   `USCD_ASSERT_SAME(a_output_free, clock, reset, out_write, !rsp_tvalid || rsp_tready)

   // Month of a presented result is always a real month.
   `USCD_ASSERT_SAME(a_month_range, clock, reset, rsp_tvalid, rsp_month_ok)

endmodule

// File: hdl/uscd_ctrl.sv
// Controller state machine that sequences the year, month, day and time steps.
module uscd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  uscd_pkg::status_type status,
   output uscd_pkg::cmd_type    cmd
);

   uscd_pkg::state_type state_ff;
   uscd_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   // State and output valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= uscd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cmd.op       = uscd_pkg::OP_NONE;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         uscd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = uscd_pkg::OP_LOAD;
               state_in = uscd_pkg::ST_YEAR;
            end
         end
         uscd_pkg::ST_YEAR: begin
            if (status.year_ge) begin
               cmd.op = uscd_pkg::OP_YEAR;
            end else begin
               state_in = uscd_pkg::ST_MONTH;
            end
         end
         uscd_pkg::ST_MONTH: begin
            if (status.month_ge) begin
               cmd.op = uscd_pkg::OP_MONTH;
            end else begin
               state_in = uscd_pkg::ST_DAY;
            end
         end
         uscd_pkg::ST_DAY: begin
            if (status.day_ge) begin
               cmd.op = uscd_pkg::OP_DAY;
            end else begin
               state_in = uscd_pkg::ST_HOUR;
            end
         end
         uscd_pkg::ST_HOUR: begin
            if (status.hour_ge) begin
               cmd.op = uscd_pkg::OP_HOUR;
            end else begin
               state_in = uscd_pkg::ST_MINUTE;
            end
         end
         uscd_pkg::ST_MINUTE: begin
            cmd.op   = uscd_pkg::OP_MINUTE;
            state_in = uscd_pkg::ST_OUTPUT;
         end
         uscd_pkg::ST_OUTPUT: begin
            // Hand over once the output register is free or being emptied.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = uscd_pkg::OP_OUTPUT;
               rsp_valid_in = 1'b1;
               state_in     = uscd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = uscd_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: hdl/uscd_datapath.sv
// Datapath: remainder register, shared subtractor, date counters and output register.
module uscd_datapath (
   input  logic                                clock,
   input  uscd_pkg::cmd_type                   cmd,
   input  logic [uscd_pkg::REQ_DATA_W-1:0]     req_data,
   output uscd_pkg::status_type                status,
   output logic [uscd_pkg::RSP_DATA_W-1:0]     rsp_data
);

   logic [31:0] rem_ff,     rem_in;
   logic [11:0] year_ff,    year_in;
   logic [6:0]  mod100_ff,  mod100_in;
   logic [8:0]  mod400_ff,  mod400_in;
   logic [3:0]  month_ff,   month_in;
   logic [4:0]  day_ff,     day_in;
   logic [4:0]  hour_ff,    hour_in;
   logic [5:0]  minute_ff,  minute_in;
   logic [uscd_pkg::RSP_DATA_W-1:0] out_ff, out_in;

   logic        leap;
   logic [31:0] year_len;
   logic [31:0] month_len;
   logic [31:0] sub_val;
   logic [24:0] min_prod;
   logic [11:0] min_secs;
   logic [5:0]  second;

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      year_ff   <= year_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      out_ff    <= out_in;
   end

   // Leap rule and the lengths of the current year and month.
   always_comb begin
      leap = ((year_ff[1:0] == 2'd0) && (mod100_ff != 7'd0)) || (mod400_ff == 9'd0);
      year_len  = leap ? uscd_pkg::SECS_LEAP_YEAR : uscd_pkg::SECS_PLAIN_YEAR;
      month_len = uscd_pkg::month_secs(month_ff, leap);
   end

   // Compares that tell the controller whether another unit fits.
   always_comb begin
      status.year_ge  = rem_ff >= year_len;
      status.month_ge = (month_ff != uscd_pkg::MONTH_DEC) && (rem_ff >= month_len);
      status.day_ge   = rem_ff >= uscd_pkg::SECS_PER_DAY;
      status.hour_ge  = rem_ff >= uscd_pkg::SECS_PER_HOUR;
   end

   // Minute by reciprocal multiply; the remainder is below one hour here.
   always_comb begin
      min_prod = 25'(rem_ff[11:0]) * 25'(uscd_pkg::MIN_RECIP);
      min_secs = 12'(minute_ff) * 12'(uscd_pkg::SECS_PER_MINUTE);
      second   = 6'(rem_ff[11:0] - min_secs);
   end

   // Subtrahend for the shared subtractor.
   always_comb begin
      case (cmd.op)
         uscd_pkg::OP_YEAR:  sub_val = year_len;
         uscd_pkg::OP_MONTH: sub_val = month_len;
         uscd_pkg::OP_DAY:   sub_val = uscd_pkg::SECS_PER_DAY;
         uscd_pkg::OP_HOUR:  sub_val = uscd_pkg::SECS_PER_HOUR;
         default:            sub_val = 32'd0;
      endcase
   end

   // Register updates for each operation.
   always_comb begin
      rem_in    = rem_ff;
      year_in   = year_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      out_in    = out_ff;
      unique case (cmd.op)
         uscd_pkg::OP_LOAD: begin
            rem_in    = req_data[31:0];
            year_in   = uscd_pkg::EPOCH_YEAR;
            mod100_in = uscd_pkg::EPOCH_MOD100;
            mod400_in = uscd_pkg::EPOCH_MOD400;
            month_in  = uscd_pkg::MONTH_JAN;
            day_in    = 5'd1;
            hour_in   = 5'd0;
         end
         uscd_pkg::OP_YEAR: begin
            rem_in    = rem_ff - sub_val;
            year_in   = year_ff + 12'd1;
            mod100_in = (mod100_ff == uscd_pkg::MOD100_LAST) ? 7'd0 : mod100_ff + 7'd1;
            mod400_in = (mod400_ff == uscd_pkg::MOD400_LAST) ? 9'd0 : mod400_ff + 9'd1;
         end
         uscd_pkg::OP_MONTH: begin
            rem_in   = rem_ff - sub_val;
            month_in = month_ff + 4'd1;
         end
         uscd_pkg::OP_DAY: begin
            rem_in = rem_ff - sub_val;
            day_in = day_ff + 5'd1;
         end
         uscd_pkg::OP_HOUR: begin
            rem_in  = rem_ff - sub_val;
            hour_in = hour_ff + 5'd1;
         end
         uscd_pkg::OP_MINUTE: begin
            minute_in = min_prod[uscd_pkg::MIN_RECIP_SHIFT +: 6];
         end
         uscd_pkg::OP_OUTPUT: begin
            out_in = {2'b00, second, minute_ff, hour_ff, day_ff, month_ff, year_ff};
         end
         default: begin
         end
      endcase
   end

   assign rsp_data = out_ff;

endmodule
